// ===== rtl/advection_diffusion_stencil_unit_defines.svh =====
// Assertion macros for the stencil unit.
`ifndef ADVECTION_DIFFUSION_STENCIL_UNIT_DEFINES_SVH
`define ADVECTION_DIFFUSION_STENCIL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ADSU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stencil unit check failed");

// Next-cycle implication, disabled during reset.
`define ADSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stencil unit check failed");

`endif

// ===== rtl/adsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package adsu_pkg;

   // csr register indexes
   localparam logic [2:0] CSR_ROW_LENGTH = 3'd0;
   localparam logic [2:0] CSR_ROW_COUNT  = 3'd1;
   localparam logic [2:0] CSR_COEF_XX    = 3'd2;
   localparam logic [2:0] CSR_COEF_YY    = 3'd3;
   localparam logic [2:0] CSR_COEF_XY    = 3'd4;

   // item modes
   localparam logic MODE_CELL  = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // multiply operations, issued in this order
   localparam logic [2:0] OP_J1 = 3'd0;
   localparam logic [2:0] OP_J2 = 3'd1;
   localparam logic [2:0] OP_XY = 3'd2;
   localparam logic [2:0] OP_XX = 3'd3;
   localparam logic [2:0] OP_YY = 3'd4;

   localparam logic [47:0] TEMP_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] TEMP_MIN = 48'h8000_0000_0000;

   typedef struct packed {
      logic       load_in;
      logic       rd_first;
      logic       rd_second;
      logic       cap_first;
      logic       cap_second;
      logic       mem_write;
      logic       diff;
      logic       mul_load;
      logic [2:0] mul_op;
      logic       mul_step;
      logic       round;
      logic       finish;
      logic       out_load;
      logic       out_interior;
   } cmd_type;

   typedef struct packed {
      logic mul_zero;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/advection_diffusion_stencil_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One explicit time step of temperature for a grid streamed in row order; each
// result beat is the cell one row above the latest input, with edge cells passed
// through and drain beats flushing the final row. One item is in work at a time.
// Interior cells form five products on the single shift-add multiplier, which retires
// one multiplier bit per cycle; the multiplier magnitude is at most 48 bits for the
// two Jacobian terms and 32 bits for each coefficient. The next beat is taken while
// a finished result still waits in the output register.
`include "advection_diffusion_stencil_unit_defines.svh"
module advection_diffusion_stencil_unit #(
   parameter int MAX_ROW_LENGTH = 64,
   parameter int FRACTION_BITS  = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire               req_mode,
   input  wire signed [47:0] req_temperature,
   input  wire signed [47:0] req_stream_value,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [47:0] rsp_new_temperature,
   output logic [5:0]        rsp_column,
   output logic [15:0]       rsp_row,
   output logic              rsp_frame_last,
   input  wire               csr_write,
   input  wire [2:0]         csr_index,
   input  wire [31:0]        csr_data
);
   localparam int AW = $clog2(MAX_ROW_LENGTH);

   logic [6:0]  row_length_ff;
   logic [15:0] row_count_ff;
   logic [31:0] coef_xx_ff, coef_yy_ff, coef_xy_ff;

   adsu_pkg::cmd_type    cmd;
   adsu_pkg::status_type status;
   logic [AW-1:0] addr;
   logic [5:0]    out_column;
   logic [15:0]   out_row;
   logic          out_last;
   logic          cell_beat;

   // csr file; writes to indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= 7'd51;
         row_count_ff  <= 16'd21;
         coef_xx_ff    <= 32'd17179869;
         coef_yy_ff    <= 32'd10995116;
         coef_xy_ff    <= 32'd13743895;
      end else if (csr_write) begin
         unique case (csr_index)
            adsu_pkg::CSR_ROW_LENGTH: row_length_ff <= csr_data[6:0];
            adsu_pkg::CSR_ROW_COUNT:  row_count_ff  <= csr_data[15:0];
            adsu_pkg::CSR_COEF_XX:    coef_xx_ff    <= csr_data;
            adsu_pkg::CSR_COEF_YY:    coef_yy_ff    <= csr_data;
            adsu_pkg::CSR_COEF_XY:    coef_xy_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer: counters, buffer addressing, multiply order, output handshake
   adsu_controller #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .row_length (row_length_ff),
      .row_count  (row_count_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status),
      .addr       (addr),
      .out_column (out_column),
      .out_row    (out_row),
      .out_last   (out_last)
   );

   // line buffers, differences, shift-add multiplier, rounding and saturation
   adsu_datapath #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
      .FRACTION_BITS  (FRACTION_BITS)
   ) u_dp (
      .clock               (clock),
      .cmd                 (cmd),
      .status              (status),
      .addr                (addr),
      .req_temperature     (req_temperature),
      .req_stream_value    (req_stream_value),
      .coef_xx             (coef_xx_ff),
      .coef_yy             (coef_yy_ff),
      .coef_xy             (coef_xy_ff),
      .out_column          (out_column),
      .out_row             (out_row),
      .out_last            (out_last),
      .rsp_new_temperature (rsp_new_temperature),
      .rsp_column          (rsp_column),
      .rsp_row             (rsp_row),
      .rsp_frame_last      (rsp_frame_last)
   );

   assign cell_beat = req_valid && req_ready && (req_mode == adsu_pkg::MODE_CELL);

   // a grid cell always starts buffer reads, so the input closes next cycle
   `ADSU_ASSERT_NEXT(a_cell_busy, clock, reset, cell_beat, !req_ready)
   // a result only appears out of work in progress
   `ADSU_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(!req_ready))
   // the frame's final beat is the last column, never column zero
   `ADSU_ASSERT_SAME(a_last_column, clock, reset, rsp_valid && rsp_frame_last, rsp_column != 6'd0)

endmodule
`default_nettype wire

// ===== rtl/adsu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module adsu_datapath #(
   parameter int MAX_ROW_LENGTH = 64,
   parameter int FRACTION_BITS  = 32
) (
   input  wire                              clock,
   input  adsu_pkg::cmd_type                cmd,
   output adsu_pkg::status_type             status,
   input  wire [$clog2(MAX_ROW_LENGTH)-1:0] addr,
   input  wire signed [47:0]                req_temperature,
   input  wire signed [47:0]                req_stream_value,
   input  wire [31:0]                       coef_xx,
   input  wire [31:0]                       coef_yy,
   input  wire [31:0]                       coef_xy,
   input  wire [5:0]                        out_column,
   input  wire [15:0]                       out_row,
   input  wire                              out_last,
   output logic signed [47:0]               rsp_new_temperature,
   output logic [5:0]                       rsp_column,
   output logic [15:0]                      rsp_row,
   output logic                             rsp_frame_last
);
   localparam int AW    = $clog2(MAX_ROW_LENGTH);
   localparam int ACC_W = (FRACTION_BITS + 86 > 134) ? FRACTION_BITS + 86 : 134;
   localparam int SW    = ACC_W - 40 - FRACTION_BITS;
   localparam int MW    = 50;
   localparam logic [AW-1:0] LAST_A = AW'(MAX_ROW_LENGTH - 1);
   localparam logic [ACC_W-1:0] RND_ONE =
      {{(ACC_W-1){1'b0}}, 1'b1} << (39 + FRACTION_BITS);

   logic [47:0] rec_mem [MAX_ROW_LENGTH];
   logic [47:0] old_mem [MAX_ROW_LENGTH];
   logic [47:0] str_mem [MAX_ROW_LENGTH];

   logic [47:0] q_rec_ff, q_old_ff, q_str_ff;
   logic signed [47:0] tn_ff, pn_ff, tc_ff, tw_ff, pc_ff, te_ff, ts_ff, pe_ff;
   logic signed [49:0] dxx_ff, dyy_ff, dxx_in, dyy_in;
   logic signed [48:0] dpe_ff, dtn_ff, dpc_ff, dte_ff;
   logic signed [ACC_W-1:0] acc_ff, mcand_ff, a_sel;
   logic [MW-1:0] mplier_ff, b_mag;
   logic signed [MW-1:0] b_sel;
   logic signed [SW-1:0] sh;
   logic signed [SW:0] sum;
   logic [SW-47:0] hi;
   logic [47:0] fin_ff, fin_in;
   logic [AW-1:0] a_p1, a_m1, rec_ra, old_ra;

   assign a_p1   = (addr == LAST_A) ? '0 : addr + 1'b1;
   assign a_m1   = (addr == '0) ? LAST_A : addr - 1'b1;
   assign rec_ra = cmd.rd_second ? a_p1 : addr;
   assign old_ra = cmd.rd_second ? addr : a_m1;

   // line buffers: one read and one write port each
   always_ff @(posedge clock) begin
      if (cmd.rd_first || cmd.rd_second) begin
         q_rec_ff <= rec_mem[rec_ra];
         q_old_ff <= old_mem[old_ra];
         q_str_ff <= str_mem[rec_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         old_mem[addr] <= tc_ff;
         rec_mem[addr] <= tn_ff;
         str_mem[addr] <= pn_ff;
      end
   end

   assign dxx_in = 50'(tw_ff) + 50'(te_ff) - (50'(tc_ff) <<< 1);
   assign dyy_in = 50'(ts_ff) + 50'(tn_ff) - (50'(tc_ff) <<< 1);

   always_comb begin
      unique case (cmd.mul_op)
         adsu_pkg::OP_J1: begin
            a_sel = ACC_W'(dpe_ff);
            b_sel = MW'(dtn_ff);
         end
         adsu_pkg::OP_J2: begin
            a_sel = ACC_W'(dpc_ff);
            b_sel = MW'(dte_ff);
         end
         adsu_pkg::OP_XY: begin
            a_sel = acc_ff;
            b_sel = MW'({1'b0, coef_xy});
         end
         adsu_pkg::OP_XX: begin
            a_sel = ACC_W'(dxx_ff) <<< FRACTION_BITS;
            b_sel = MW'({1'b0, coef_xx});
         end
         adsu_pkg::OP_YY: begin
            a_sel = ACC_W'(dyy_ff) <<< FRACTION_BITS;
            b_sel = MW'({1'b0, coef_yy});
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
         end
      endcase
   end

   assign b_mag = b_sel[MW-1] ? MW'(-b_sel) : MW'(b_sel);

   // round half up, drop fraction, add centre, saturate
   assign sh   = SW'(acc_ff >>> (40 + FRACTION_BITS));
   assign sum  = (SW+1)'(sh) + (SW+1)'(tc_ff);
   assign hi   = sum[SW:47];
   assign fin_in = ((hi == '0) || (hi == '1)) ? sum[47:0]
                 : (sum[SW] ? adsu_pkg::TEMP_MIN : adsu_pkg::TEMP_MAX);

   assign status.mul_zero = (mplier_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         tn_ff <= req_temperature;
         pn_ff <= req_stream_value;
      end
      if (cmd.cap_first) begin
         tc_ff <= q_rec_ff;
         tw_ff <= q_old_ff;
         pc_ff <= q_str_ff;
      end
      if (cmd.cap_second) begin
         te_ff <= q_rec_ff;
         ts_ff <= q_old_ff;
         pe_ff <= q_str_ff;
      end
      if (cmd.diff) begin
         dxx_ff <= dxx_in;
         dyy_ff <= dyy_in;
         dpe_ff <= 49'(pe_ff) - 49'(pc_ff);
         dtn_ff <= 49'(tn_ff) - 49'(tc_ff);
         dpc_ff <= 49'(pc_ff) - 49'(pn_ff);
         dte_ff <= 49'(te_ff) - 49'(tc_ff);
      end
      // shift-add multiplier, operands sign-folded so the multiplier is a magnitude
      if (cmd.mul_load) begin
         mcand_ff  <= b_sel[MW-1] ? -a_sel : a_sel;
         mplier_ff <= b_mag;
         if (cmd.mul_op == adsu_pkg::OP_J1 || cmd.mul_op == adsu_pkg::OP_XY) begin
            acc_ff <= '0;
         end
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
      end else if (cmd.round) begin
         acc_ff <= acc_ff + RND_ONE;
      end
      if (cmd.finish) begin
         fin_ff <= fin_in;
      end
      if (cmd.out_load) begin
         rsp_new_temperature <= cmd.out_interior ? fin_ff : tc_ff;
         rsp_column          <= out_column;
         rsp_row             <= out_row;
         rsp_frame_last      <= out_last;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/adsu_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
module adsu_controller #(
   parameter int MAX_ROW_LENGTH = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_mode,
   input  wire [6:0]                        row_length,
   input  wire [15:0]                       row_count,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output adsu_pkg::cmd_type                cmd,
   input  adsu_pkg::status_type             status,
   output logic [$clog2(MAX_ROW_LENGTH)-1:0] addr,
   output logic [5:0]                       out_column,
   output logic [15:0]                      out_row,
   output logic                             out_last
);
   localparam int AW = $clog2(MAX_ROW_LENGTH);
   localparam int CW = $clog2(MAX_ROW_LENGTH + 1);
   localparam int LW = (CW > 7) ? CW : 7;
   localparam int XW = (CW > 6) ? CW : 6;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD0   = 4'd1;
   localparam logic [3:0] S_RD1   = 4'd2;
   localparam logic [3:0] S_RD2   = 4'd3;
   localparam logic [3:0] S_WR    = 4'd4;
   localparam logic [3:0] S_DIFF  = 4'd5;
   localparam logic [3:0] S_MLD   = 4'd6;
   localparam logic [3:0] S_MSTEP = 4'd7;
   localparam logic [3:0] S_RND   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [CW-1:0] col_ff, col_in, dc_ff, dc_in, cur_c_ff, cur_c_in;
   logic [15:0] row_ff, row_in, out_row_ff, out_row_in;
   logic out_last_ff, out_last_in;
   logic grid_ff, grid_in, has_res_ff, has_res_in, interior_ff, interior_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] rl_ext, len_ext;
   logic [CW-1:0] len, c, dcl;
   logic [XW-1:0] col_x;
   logic [15:0] cnt, r, orow;
   logic accept, out_free;

   assign rl_ext  = LW'(row_length);
   assign len_ext = (rl_ext < LW'(3)) ? LW'(3)
                  : ((rl_ext > LW'(MAX_ROW_LENGTH)) ? LW'(MAX_ROW_LENGTH) : rl_ext);
   assign len  = CW'(len_ext);
   assign cnt  = (row_count < 16'd3) ? 16'd3 : row_count;
   assign c    = (col_ff >= len) ? len - 1'b1 : col_ff;
   assign r    = (row_ff >= cnt) ? cnt - 1'b1 : row_ff;
   assign orow = r - 1'b1;
   assign dcl  = (dc_ff > len) ? len : dc_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign addr      = cur_c_ff[AW-1:0];
   assign col_x     = XW'(cur_c_ff);
   assign out_column = col_x[5:0];
   assign out_row   = out_row_ff;
   assign out_last  = out_last_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_op   = op_ff;
      state_in     = state_ff;
      op_in        = op_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      dc_in        = dc_ff;
      cur_c_in     = cur_c_ff;
      out_row_in   = out_row_ff;
      out_last_in  = out_last_ff;
      grid_in      = grid_ff;
      has_res_in   = has_res_ff;
      interior_in  = interior_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_in = 1'b1;
               if (req_mode == adsu_pkg::MODE_DRAIN) begin
                  if (dc_ff != '0) begin
                     cur_c_in    = len - dcl;
                     out_row_in  = cnt - 1'b1;
                     out_last_in = (dcl == CW'(1));
                     dc_in       = dcl - 1'b1;
                     grid_in     = 1'b0;
                     has_res_in  = 1'b1;
                     interior_in = 1'b0;
                     state_in    = S_RD0;
                  end
               end else begin
                  dc_in       = '0;
                  cur_c_in    = c;
                  out_row_in  = orow;
                  out_last_in = 1'b0;
                  grid_in     = 1'b1;
                  has_res_in  = (r != '0);
                  interior_in = !((c == '0) || (c == len - 1'b1) || (orow == '0));
                  state_in    = S_RD0;
                  if (c == len - 1'b1) begin
                     col_in = '0;
                     if (r == cnt - 1'b1) begin
                        row_in = '0;
                        dc_in  = len;
                     end else begin
                        row_in = r + 1'b1;
                     end
                  end else begin
                     col_in = c + 1'b1;
                     row_in = r;
                  end
               end
            end
         end
         S_RD0: begin
            cmd.rd_first = 1'b1;
            state_in     = S_RD1;
         end
         S_RD1: begin
            cmd.rd_second = 1'b1;
            cmd.cap_first = 1'b1;
            state_in      = S_RD2;
         end
         S_RD2: begin
            cmd.cap_second = 1'b1;
            state_in       = S_WR;
         end
         S_WR: begin
            cmd.mem_write = grid_ff;
            if (!has_res_ff) begin
               state_in = S_IDLE;
            end else if (interior_ff) begin
               state_in = S_DIFF;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            op_in    = adsu_pkg::OP_J1;
            state_in = S_MLD;
         end
         S_MLD: begin
            cmd.mul_load = 1'b1;
            state_in     = S_MSTEP;
         end
         S_MSTEP: begin
            if (status.mul_zero) begin
               if (op_ff == adsu_pkg::OP_YY) begin
                  state_in = S_RND;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = S_MLD;
               end
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_RND: begin
            cmd.round = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_interior = interior_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= adsu_pkg::OP_J1;
         col_ff       <= '0;
         row_ff       <= '0;
         dc_ff        <= '0;
         grid_ff      <= 1'b0;
         has_res_ff   <= 1'b0;
         interior_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         dc_ff        <= dc_in;
         grid_ff      <= grid_in;
         has_res_ff   <= has_res_in;
         interior_ff  <= interior_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_c_ff    <= cur_c_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
   end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

   // longest single beat is an interior cell; allow slack
   localparam int SETTLE_CYCLES = 260;
   localparam int BEAT_TARGET   = 1275;

   typedef struct packed {
      logic signed [47:0] temp;
      logic [5:0]         col;
      logic [15:0]        row;
      logic               last;
   } cell_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = adsu_pkg::MODE_CELL;
   logic signed [47:0] req_temperature = '0;
   logic signed [47:0] req_stream_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [47:0] rsp_new_temperature;
   logic [5:0]         rsp_column;
   logic [15:0]        rsp_row;
   logic               rsp_frame_last;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = adsu_pkg::CSR_ROW_LENGTH;
   logic [31:0]        csr_data = '0;

   advection_diffusion_stencil_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_temperature(req_temperature), .req_stream_value(req_stream_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_temperature(rsp_new_temperature), .rsp_column(rsp_column),
      .rsp_row(rsp_row), .rsp_frame_last(rsp_frame_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: line buffers, counters and register shadow
   // ---------------------------------------------------------------
   logic signed [47:0] temp_recent [64];
   logic signed [47:0] temp_older  [64];
   logic signed [47:0] stream_recent [64];
   int                 col_ctr, row_ctr, drain_ctr;
   logic [6:0]         cfg_row_length = 7'd51;
   logic [15:0]        cfg_row_count  = 16'd21;
   logic [31:0]        cfg_xx = 32'd17179869;
   logic [31:0]        cfg_yy = 32'd10995116;
   logic [31:0]        cfg_xy = 32'd13743895;

   cell_result_type    cells_due [$];
   int                 errors = 0;
   int                 beats_sent = 0;
   bit                 calm = 0;   // no gaps, and no new back-pressure runs, while set

   function automatic int active_length();
      if (cfg_row_length < 3) return 3;
      if (cfg_row_length > 64) return 64;
      return int'(cfg_row_length);
   endfunction

   function automatic int active_rows();
      return (cfg_row_count < 3) ? 3 : int'(cfg_row_count);
   endfunction

   // FTCS update with Jacobian term; exact in 192 bits, round half up, saturate
   function automatic logic signed [47:0] stepped_temperature(
         int c, logic signed [47:0] tn_in, logic signed [47:0] pn_in);
      logic signed [191:0] tc, tw, te, ts, pc, pe, tn, pn, cxx, cyy, cxy, acc;
      logic signed [191:0] sat_hi, sat_lo;
      tc  = temp_recent[c];
      tw  = temp_older[c - 1];
      te  = temp_recent[c + 1];
      ts  = temp_older[c];
      pc  = stream_recent[c];
      pe  = stream_recent[c + 1];
      tn  = tn_in;
      pn  = pn_in;
      cxx = {160'd0, cfg_xx};
      cyy = {160'd0, cfg_yy};
      cxy = {160'd0, cfg_xy};
      acc = ((cxx * (tw + te - 2 * tc) + cyy * (ts + tn - 2 * tc)) <<< 32)
            + cxy * ((pe - pc) * (tn - tc) + (pc - pn) * (te - tc))
            + (192'sd1 <<< 71);
      acc = (acc >>> 72) + tc;
      sat_hi = 192'sh7FFF_FFFF_FFFF;
      sat_lo = -sat_hi - 1;
      if (acc > sat_hi) return adsu_pkg::TEMP_MAX;
      if (acc < sat_lo) return adsu_pkg::TEMP_MIN;
      return acc[47:0];
   endfunction

   task automatic predict_beat(logic mode, logic signed [47:0] tn,
                               logic signed [47:0] pn);
      int len, cnt, c, r;
      cell_result_type res;
      len = active_length();
      cnt = active_rows();
      if (mode == adsu_pkg::MODE_DRAIN) begin
         if (drain_ctr == 0) return;
         if (drain_ctr > len) drain_ctr = len;
         res.temp = temp_recent[len - drain_ctr];
         res.col  = 6'(len - drain_ctr);
         res.row  = 16'(cnt - 1);
         res.last = (drain_ctr == 1);
         cells_due.push_back(res);
         drain_ctr--;
      end else begin
         drain_ctr = 0;
         c = (col_ctr >= len) ? len - 1 : col_ctr;
         r = (row_ctr >= cnt) ? cnt - 1 : row_ctr;
         if (r > 0) begin
            // edge cells pass through; the rest get the stencil
            if (c == 0 || c == len - 1 || r - 1 == 0 || r - 1 == cnt - 1)
               res.temp = temp_recent[c];
            else
               res.temp = stepped_temperature(c, tn, pn);
            res.col  = 6'(c);
            res.row  = 16'(r - 1);
            res.last = 1'b0;
            cells_due.push_back(res);
         end
         temp_older[c]    = temp_recent[c];
         temp_recent[c]   = tn;
         stream_recent[c] = pn;
         if (c == len - 1) begin
            col_ctr = 0;
            if (r == cnt - 1) begin
               row_ctr   = 0;
               drain_ctr = len;
            end else begin
               row_ctr = r + 1;
            end
         end else begin
            col_ctr = c + 1;
            row_ctr = r;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 200);
   endfunction

   function automatic logic signed [47:0] pick_value();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return adsu_pkg::TEMP_MAX;
         1: return adsu_pkg::TEMP_MIN;
         2: return '0;
         3, 4, 5: return raw[47:0];
         default: return 48'($signed($urandom)) <<< $urandom_range(0, 12);
      endcase
   endfunction

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 1 << 26);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Stimulus driving
   // ---------------------------------------------------------------
   task automatic send_beat(logic mode, logic signed [47:0] t, logic signed [47:0] p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_temperature  <= t;
      req_stream_value <= p;
      do @(posedge clock); while (!req_ready);
      predict_beat(mode, t, p);
      beats_sent++;
   endtask

   task automatic send_cells(int n);
      repeat (n) send_beat(adsu_pkg::MODE_CELL, pick_value(), pick_value());
   endtask

   task automatic send_drains(int n);
      repeat (n) send_beat(adsu_pkg::MODE_DRAIN, pick_value(), pick_value());
   endtask

   // wait out every expected beat, then the tail of any silent beat in work
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (cells_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      case (idx)
         adsu_pkg::CSR_ROW_LENGTH: cfg_row_length = value[6:0];
         adsu_pkg::CSR_ROW_COUNT:  cfg_row_count  = value[15:0];
         adsu_pkg::CSR_COEF_XX:    cfg_xx = value;
         adsu_pkg::CSR_COEF_YY:    cfg_yy = value;
         adsu_pkg::CSR_COEF_XY:    cfg_xy = value;
         default: ;
      endcase
   endtask

   task automatic csr_release();
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int len, int cnt, logic [31:0] xx, logic [31:0] yy,
                            logic [31:0] xy);
      settle_idle();
      write_csr(adsu_pkg::CSR_ROW_LENGTH, 32'(len));
      write_csr(adsu_pkg::CSR_ROW_COUNT, 32'(cnt));
      write_csr(adsu_pkg::CSR_COEF_XX, xx);
      write_csr(adsu_pkg::CSR_COEF_YY, yy);
      write_csr(adsu_pkg::CSR_COEF_XY, xy);
      csr_release();
   endtask

   // ---------------------------------------------------------------
   // Result side: random back-pressure and the checker
   // ---------------------------------------------------------------
   int ready_run = 0;
   always @(posedge clock) begin
      if (ready_run > 0) begin
         ready_run <= ready_run - 1;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         case ($urandom_range(0, 49))
            0: begin
               rsp_ready <= 1'b0;
               ready_run <= $urandom_range(50, 200);
            end
            1, 2, 3, 4: begin
               rsp_ready <= 1'b0;
               ready_run <= $urandom_range(4, 10);
            end
            5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19: begin
               rsp_ready <= 1'b0;
               ready_run <= $urandom_range(0, 2);
            end
            default: begin
               rsp_ready <= 1'b1;
               ready_run <= $urandom_range(0, 30);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cells_due.size() == 0) begin
            $display("%0t: unexpected beat: temp %h col %0d row %0d last %0d",
                     $time, rsp_new_temperature, rsp_column, rsp_row, rsp_frame_last);
            errors++;
         end else begin
            want = cells_due.pop_front();
            if (rsp_new_temperature !== want.temp) begin
               $display("%0t: new_temperature expected %h actual %h",
                        $time, want.temp, rsp_new_temperature);
               errors++;
            end
            if (rsp_column !== want.col) begin
               $display("%0t: column expected %0d actual %0d", $time, want.col, rsp_column);
               errors++;
            end
            if (rsp_row !== want.row) begin
               $display("%0t: row expected %0d actual %0d", $time, want.row, rsp_row);
               errors++;
            end
            if (rsp_frame_last !== want.last) begin
               $display("%0t: frame_last expected %0d actual %0d",
                        $time, want.last, rsp_frame_last);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // smallest grid, largest coefficients: the one interior cell saturates
   task automatic test_min_frame();
      logic signed [47:0] grid_t [9];
      logic signed [47:0] grid_p [9];
      grid_t = '{adsu_pkg::TEMP_MAX, adsu_pkg::TEMP_MIN, adsu_pkg::TEMP_MAX,
                 adsu_pkg::TEMP_MAX, adsu_pkg::TEMP_MIN, adsu_pkg::TEMP_MAX,
                 adsu_pkg::TEMP_MIN, adsu_pkg::TEMP_MAX, 48'sd0};
      grid_p = '{adsu_pkg::TEMP_MIN, adsu_pkg::TEMP_MAX, adsu_pkg::TEMP_MIN,
                 48'sd0, adsu_pkg::TEMP_MAX, adsu_pkg::TEMP_MIN,
                 adsu_pkg::TEMP_MAX, adsu_pkg::TEMP_MIN, adsu_pkg::TEMP_MAX};
      configure(3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      foreach (grid_t[i]) send_beat(adsu_pkg::MODE_CELL, grid_t[i], grid_p[i]);
      // three drains flush the last row, the fourth has nothing pending
      send_drains(4);
   endtask

   // clamped sizes, zero coefficients, unused index, abandoned drain
   task automatic test_clamped_regs();
      settle_idle();
      write_csr(3'd7, 32'hDEAD_BEEF);
      write_csr(adsu_pkg::CSR_ROW_LENGTH, 32'd0);
      write_csr(adsu_pkg::CSR_ROW_COUNT, 32'd0);
      write_csr(adsu_pkg::CSR_COEF_XX, 32'd0);
      write_csr(adsu_pkg::CSR_COEF_YY, 32'd0);
      write_csr(adsu_pkg::CSR_COEF_XY, 32'd0);
      csr_release();
      send_cells(9);
      send_drains(2);   // the third is dropped by the next cell beat unless a stray drain takes it
   endtask

   task automatic random_geometry(output int len, output int cnt);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)      len = $urandom_range(3, 8);
      else if (roll < 90) len = $urandom_range(9, 20);
      else if (roll < 95) len = $urandom_range(61, 64);
      else if (roll < 97) len = $urandom_range(0, 2);
      else                len = $urandom_range(65, 127);
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      if ((len > 64 || len > 20) && cnt > 3) cnt = 3;
   endtask

   // whole frame, then the drain in one of its shapes
   task automatic run_frame(bit reconfig);
      int len, cnt, roll;
      if (reconfig) begin
         random_geometry(len, cnt);
         configure(len, cnt, pick_coef(), pick_coef(), pick_coef());
      end
      send_cells(active_length() * active_rows());
      roll = $urandom_range(0, 99);
      if (roll < 70)      send_drains(active_length());
      else if (roll < 85) send_drains($urandom_range(0, active_length() - 1));
      else                send_drains(active_length() + $urandom_range(1, 3));
   endtask

   // shrink both sizes part way through a row: counters get clamped
   task automatic shrink_mid_frame();
      int len, k;
      len = $urandom_range(5, 10);
      k   = $urandom_range(3, len - 1);
      configure(len, $urandom_range(0, 1) ? 65535 : $urandom_range(5, 200),
                pick_coef(), pick_coef(), pick_coef());
      send_cells(3 * len + k);
      settle_idle();
      write_csr(adsu_pkg::CSR_ROW_LENGTH, 32'($urandom_range(3, k)));
      write_csr(adsu_pkg::CSR_ROW_COUNT, 32'($urandom_range(0, 3)));
      csr_release();
      // taken as last column of last row: ends the frame
      send_cells(1);
      send_drains(active_length());
   endtask

   // row length cut between frame end and drain
   task automatic shrink_before_drain();
      int len;
      len = $urandom_range(6, 12);
      configure(len, $urandom_range(3, 4), pick_coef(), pick_coef(), pick_coef());
      send_cells(len * active_rows());
      settle_idle();
      write_csr(adsu_pkg::CSR_ROW_LENGTH, 32'($urandom_range(3, len - 1)));
      csr_release();
      send_drains(len);
   endtask

   task automatic test_random_frames();
      int roll;
      while (beats_sent < BEAT_TARGET) begin
         calm = ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 45)      run_frame(1);
         else if (roll < 75) run_frame(0);
         else if (roll < 85) shrink_mid_frame();
         else if (roll < 93) shrink_before_drain();
         else                send_drains($urandom_range(1, 3));   // stray drains
      end
      calm = 0;
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      col_ctr = 0;
      row_ctr = 0;
      drain_ctr = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_min_frame();
      test_clamped_regs();
      test_random_frames();
      settle_idle();
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // guard: several times the slowest legal run
   initial begin
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/adsu_pkg.sv
rtl/adsu_datapath.sv
rtl/adsu_controller.sv
rtl/advection_diffusion_stencil_unit.sv
tb/tb.sv
